### rtl/gaer_pkg.sv
`timescale 1ns / 1ps

package gaer_pkg;

  // Data and register widths.
  localparam int DATA_W = 32;
  localparam int CFG_W  = 17;
  localparam int WIDE_W = 36;

  // Gains are unsigned Q1.16; this code is 1.0.
  localparam logic [CFG_W-1:0] GAIN_ONE       = 17'd65536;
  localparam logic [CFG_W-1:0] DISCOUNT_RESET = 17'd64880;
  localparam logic [CFG_W-1:0] DECAY_RESET    = 17'd62259;

  // Register indexes on the configuration port.
  localparam logic [0:0] CFG_DISCOUNT = 1'b0;
  localparam logic [0:0] CFG_DECAY    = 1'b1;

  // Default depth of the command queue between front and back.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Saturation limits held at the working width.
  localparam logic signed [WIDE_W-1:0] SAT_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = 36'shF_8000_0000;

  // One classified step as it travels through the queue.
  typedef struct packed {
    logic signed [DATA_W-1:0] reward;
    logic signed [DATA_W-1:0] value;
    logic                     use_history;
  } gaer_cmd_t;

  // Clamp a wide signed sum to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (x < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  // True when the wide sum lies outside the 32-bit range.
  function automatic logic sat_hit(input logic signed [WIDE_W-1:0] x);
    return (x > SAT_MAX) || (x < SAT_MIN);
  endfunction

  // A gain above 1.0 is used as 1.0.
  function automatic logic [CFG_W-1:0] gain(input logic [CFG_W-1:0] r);
    return (r > GAIN_ONE) ? GAIN_ONE : r;
  endfunction

endpackage

### rtl/gae_advantage_recursion.sv
`timescale 1ns / 1ps

// Generalized advantage estimation over trajectory steps fed in reverse time
// order, signed Q16.16 in and out with saturation. Each word on the input
// stream carries reward and value estimate in tdata, the episode-done bit in
// tuser and the sequence-tail bit in tlast; each output word carries the
// advantage and the value target in tdata and the overflow flag in tuser,
// exactly one output word per input word. A short command queue takes input
// words while the arithmetic engine works, so input and output stall
// independently. The engine takes a new step only when the last is done:
// it passes each step twice through one shared 33 x 32 multiplier
// (discount times next value, then discount times trace decay times the
// previous advantage), and the next step needs the advantage just formed.
// Results are loaded into the output register from the finish state. The gain
// product is registered from the configuration, so registers may be written
// whenever the block is idle; there is no clearing pass after reset.

module gae_advantage_recursion import gaer_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [63:0]       s_tdata,   // reward [31:0], value_estimate [63:32]
  input  logic              s_tuser,   // episode_done
  input  logic              s_tlast,   // sequence_tail
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,   // advantage [31:0], value_target [63:32]
  output logic              m_tuser,   // overflow
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic [CFG_W-1:0] discount;
  logic [CFG_W-1:0] trace_decay;
  logic [32:0]      carry_gain;
  logic [33:0]      gain_prod;
  logic             cmd_valid;
  gaer_cmd_t        cmd;
  logic             cmd_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      discount    <= DISCOUNT_RESET;
      trace_decay <= DECAY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DISCOUNT: discount    <= cfg_data;
        CFG_DECAY:    trace_decay <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Combined gain for the carry term, at most 1.0 in Q1.32.
  assign gain_prod = gain(discount) * gain(trace_decay);

  always_ff @(posedge clk) begin
    carry_gain <= gain_prod[32:0];
  end

  gaer_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  gaer_back u_back (
    .clk           (clk),
    .rst           (rst),
    .discount_gain (gain(discount)),
    .carry_gain    (carry_gain),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser)
  );

  // A unity gain product has no fractional bits left over.
  a_unity_gain: assert property (@(posedge clk) disable iff (rst)
    carry_gain[32] |-> carry_gain[31:0] == 32'd0)
    else $error("gain product above one");

endmodule

### rtl/gaer_front.sv
`timescale 1ns / 1ps

module gaer_front import gaer_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [63:0]       s_tdata,  // reward [31:0], value_estimate [63:32]
  input  logic              s_tuser,  // episode_done
  input  logic              s_tlast,  // sequence_tail
  output logic              cmd_valid,
  output gaer_cmd_t         cmd,
  input  logic              cmd_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  gaer_cmd_t        queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  gaer_cmd_t        incoming;
  logic             push;
  logic             pop;

  // Classify the word: history is used only when the step neither starts a
  // sequence nor ends an episode; otherwise both bootstrap and carry are zero.
  always_comb begin
    incoming.reward      = s_tdata[31:0];
    incoming.value       = s_tdata[63:32];
    incoming.use_history = !s_tuser && !s_tlast;
  end

  assign s_tready  = (count != CNT_FULL);
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_pop && (count != '0);
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue fill count above depth");

endmodule

### rtl/gaer_back.sv
`timescale 1ns / 1ps

module gaer_back import gaer_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CFG_W-1:0]     discount_gain,
  input  logic [32:0]          carry_gain,  // discount * trace_decay, unsigned Q1.32
  input  logic                 cmd_valid,
  input  gaer_cmd_t            cmd,
  output logic                 cmd_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,  // advantage [31:0], value_target [63:32]
  output logic                 m_tuser   // overflow
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BOOT,
    S_CARRY,
    S_FINISH
  } state_t;

  state_t                   state;
  gaer_cmd_t                cur;
  logic signed [64:0]       prod;
  logic signed [DATA_W-1:0] delta;
  logic                     ovf;
  logic signed [DATA_W-1:0] later_value;
  logic signed [DATA_W-1:0] running_adv;

  logic signed [32:0]       mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [DATA_W-1:0] boot_src;
  logic signed [DATA_W-1:0] prev_adv;
  logic signed [64:0]       boot_full;
  logic signed [64:0]       carry_full;
  logic signed [32:0]       boot;
  logic signed [32:0]       carry;
  logic signed [WIDE_W-1:0] delta_wide;
  logic signed [WIDE_W-1:0] gae_wide;
  logic signed [WIDE_W-1:0] target_wide;
  logic signed [DATA_W-1:0] gae;
  logic signed [DATA_W-1:0] target;
  logic                     out_free;

  // History of the later step, cut to zero on a tail or a done step.
  assign boot_src = cur.use_history ? later_value : '0;
  assign prev_adv = cur.use_history ? running_adv : '0;
  assign out_free = !m_tvalid || m_tready;

  // Shared multiplier operands: discount * next value first, then
  // (discount * trace_decay) * previous advantage.
  always_comb begin
    if (state == S_CARRY) begin
      mul_a = {1'b0, carry_gain[31:0]};
      mul_b = prev_adv;
    end else begin
      mul_a = {16'b0, discount_gain};
      mul_b = boot_src;
    end
  end

  // Bootstrap term rounded to Q16.16, then delta formed and saturated.
  always_comb begin
    boot_full  = (prod + 65'sh0_0000_8000) >>> 16;
    boot       = boot_full[32:0];
    delta_wide = {{4{cur.reward[31]}}, cur.reward}
               + {{3{boot[32]}}, boot}
               - {{4{cur.value[31]}}, cur.value};
  end

  // Carry term rounded to Q16.16; a unity product passes the advantage through.
  always_comb begin
    carry_full  = (prod + 65'sh0_8000_0000) >>> 32;
    carry       = carry_gain[32] ? {prev_adv[31], prev_adv} : carry_full[32:0];
    gae_wide    = {{4{delta[31]}}, delta} + {{3{carry[32]}}, carry};
    gae         = sat32(gae_wide);
    target_wide = {{4{gae[31]}}, gae} + {{4{cur.value[31]}}, cur.value};
    target      = sat32(target_wide);
  end

  assign cmd_pop = cmd_valid && ((state == S_IDLE) || (state == S_FINISH && out_free));

  // Sequencer, working registers, history and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      later_value <= '0;
      running_adv <= '0;
    end else begin
      if (state == S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            state <= S_BOOT;
          end
        end
        S_BOOT: begin
          prod  <= mul_a * mul_b;
          state <= S_CARRY;
        end
        S_CARRY: begin
          delta <= sat32(delta_wide);
          ovf   <= sat_hit(delta_wide);
          prod  <= mul_a * mul_b;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            m_tdata         <= {target, gae};
            m_tuser         <= ovf || sat_hit(gae_wide) || sat_hit(target_wide);
            later_value     <= cur.value;
            running_adv     <= gae;
            if (cmd_valid) begin
              cur   <= cmd;
              state <= S_BOOT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A popped command always starts a bootstrap multiply.
  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> state == S_BOOT)
    else $error("popped command did not start the engine");

  // The carry multiply follows the bootstrap multiply directly.
  a_carry_order: assert property (@(posedge clk) disable iff (rst)
    state == S_CARRY |-> $past(state) == S_BOOT)
    else $error("carry step entered out of order");

  // History moves only when a result word is loaded.
  a_history_hold: assert property (@(posedge clk) disable iff (rst)
    !(state == S_FINISH && out_free) |=> $stable(running_adv) && $stable(later_value))
    else $error("history changed without a result");

endmodule

### tb/sv/gae_advantage_recursion_test.sv
`timescale 1ns / 1ps

module gae_advantage_recursion_test;
  import gaer_pkg::*;

  typedef logic signed [79:0] wide_t;

  typedef struct {
    logic signed [31:0] reward;
    logic signed [31:0] value_estimate;
    logic               done;
    logic               tail;
  } traj_step_t;

  typedef struct {
    logic signed [31:0] advantage;
    logic signed [31:0] value_target;
    logic               overflow;
  } gae_result_t;

  localparam wide_t Q_MAX       = 80'sh7FFF_FFFF;
  localparam wide_t Q_MIN       = -80'sd2147483648;
  localparam wide_t BOOT_HALF   = 80'sd32768;
  localparam wide_t CARRY_HALF  = 80'sd2147483648;
  localparam int    HOLD_CYCLES = 120;
  localparam int    CYCLE_LIMIT = 100000;
  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE   = 32'sd65536;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [63:0]      s_tdata = '0;   // reward [31:0], value_estimate [63:32]
  logic             s_tuser = 1'b0; // episode_done
  logic             s_tlast = 1'b0; // sequence_tail
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [63:0]      m_tdata;        // advantage [31:0], value_target [63:32]
  logic             m_tuser;        // overflow
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = CFG_DISCOUNT;
  logic [CFG_W-1:0] cfg_data = '0;

  // Words waiting to be offered, and advantages expected back in order.
  traj_step_t  steps_to_send[$];
  gae_result_t expected_advantages[$];

  // Our own copy of the gains and of the recursion history.
  logic [CFG_W-1:0]   discount_cfg = DISCOUNT_RESET;
  logic [CFG_W-1:0]   decay_cfg    = DECAY_RESET;
  logic signed [31:0] later_value  = '0;
  logic signed [31:0] running_adv  = '0;

  traj_step_t  next_step;
  traj_step_t  seen_step;
  gae_result_t want;
  logic        word_in_taken = 1'b0;
  logic        steady = 1'b0;
  logic        hold_off_request = 1'b0;
  logic        hold_off_started = 1'b0;
  int          hold_left = 0;
  int          steps_queued = 0;
  int          steps_accepted = 0;
  int          results_checked = 0;
  int          saturated_results = 0;
  int          mismatch_count = 0;
  int          gain_settings = 1;
  int          cycle_count = 0;

  gae_advantage_recursion dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clamp a wide sum to Q16.16 and flag whether it had to be clamped.
  function automatic logic signed [31:0] clip32(input wide_t x, output bit hit);
    hit = (x > Q_MAX) || (x < Q_MIN);
    if (x > Q_MAX) begin
      return S_MAX;
    end else if (x < Q_MIN) begin
      return S_MIN;
    end
    return x[31:0];
  endfunction

  // One step of the advantage recursion; updates the held history.
  function automatic gae_result_t advance_gae(traj_step_t st);
    wide_t g, l, bootstrap_src, prior_adv, bootstrap, carry;
    logic signed [31:0] delta, adv;
    bit hit_delta, hit_adv, hit_target;
    gae_result_t res;
    g = wide_t'((discount_cfg > GAIN_ONE) ? GAIN_ONE : discount_cfg);
    l = wide_t'((decay_cfg > GAIN_ONE) ? GAIN_ONE : decay_cfg);
    bootstrap_src = st.tail ? wide_t'(0) : wide_t'(later_value);
    prior_adv  = st.tail ? wide_t'(0) : wide_t'(running_adv);
    bootstrap = '0;
    carry = '0;
    if (!st.done) begin
      bootstrap = (g * bootstrap_src + BOOT_HALF) >>> 16;
      carry = (g * l * prior_adv + CARRY_HALF) >>> 32;
    end
    delta = clip32(wide_t'(st.reward) + bootstrap - wide_t'(st.value_estimate), hit_delta);
    adv = clip32(wide_t'(delta) + carry, hit_adv);
    res.advantage = adv;
    res.value_target = clip32(wide_t'(adv) + wide_t'(st.value_estimate), hit_target);
    res.overflow = hit_delta || hit_adv || hit_target;
    later_value = st.value_estimate;
    running_adv = adv;
    return res;
  endfunction

  // Mostly moderate values, with some extremes and some fully random words.
  function automatic logic signed [31:0] random_q16();
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return S_MAX;
          1: return S_MIN;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return int'($urandom_range(24'hFF_FFFF)) - 8388608;
    endcase
  endfunction

  task automatic add_step(logic signed [31:0] r, logic signed [31:0] v, logic done,
                          logic tail);
    traj_step_t st;
    st.reward = r;
    st.value_estimate = v;
    st.done = done;
    st.tail = tail;
    steps_to_send.push_back(st);
    steps_queued++;
  endtask

  // Mostly whole sequences, tail first; about one draw in ten is a single noise word.
  task automatic queue_random_steps(int count);
    int left;
    int run;
    left = count;
    @(posedge clk);
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        add_step($urandom, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
        left--;
      end else begin
        run = $urandom_range(10, 1);
        if (run > left) begin
          run = left;
        end
        for (int i = 0; i < run; i++) begin
          add_step(random_q16(), random_q16(), $urandom_range(7) == 0, i == 0);
        end
        left -= run;
      end
    end
  endtask

  // Sender holds off until every queued word has come back.
  task automatic wait_drained();
    while (steps_accepted != steps_queued || expected_advantages.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic set_gains(logic [CFG_W-1:0] disc, logic [CFG_W-1:0] decay);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DISCOUNT;
    cfg_data <= disc;
    @(negedge clk);
    cfg_index <= CFG_DECAY;
    cfg_data <= decay;
    @(negedge clk);
    cfg_we <= 1'b0;
    discount_cfg = disc;
    decay_cfg = decay;
    gain_settings++;
  endtask

  // Sender: offers the next word once the current one has been taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_in_taken) begin
      if (steps_to_send.size() != 0 && (steady || $urandom_range(99) >= 7)) begin
        next_step = steps_to_send.pop_front();
        s_tdata <= {next_step.value_estimate, next_step.reward};
        s_tuser <= next_step.done;
        s_tlast <= next_step.tail;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off_request && !hold_off_started) begin
      hold_off_started <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 7);
    end
  end

  // Predict on every accepted word and check every delivered word.
  always @(posedge clk) begin
    if (rst) begin
      word_in_taken <= 1'b0;
    end else begin
      word_in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        seen_step.reward = s_tdata[31:0];
        seen_step.value_estimate = s_tdata[63:32];
        seen_step.done = s_tuser;
        seen_step.tail = s_tlast;
        expected_advantages.push_back(advance_gae(seen_step));
        steps_accepted <= steps_accepted + 1;
      end
      if (m_tvalid && m_tready) begin
        if (expected_advantages.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Unexpected word: tdata %h tuser %b", m_tdata, m_tuser);
          end
        end else begin
          want = expected_advantages.pop_front();
          results_checked++;
          if (want.overflow) begin
            saturated_results++;
          end
          if (m_tdata[31:0] !== want.advantage || m_tdata[63:32] !== want.value_target ||
              m_tuser !== want.overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Word %0d: advantage exp %h got %h, target exp %h got %h, ovf exp %b got %b",
                       results_checked, want.advantage, m_tdata[31:0], want.value_target,
                       m_tdata[63:32], want.overflow, m_tuser);
            end
          end
        end
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL gae_advantage_recursion");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words at the reset gains; the first one has no tail before it.
    @(posedge clk);
    add_step(ONE, 32'sd32768, 1'b0, 1'b0);
    add_step(S_MAX, S_MIN, 1'b0, 1'b1);
    add_step(S_MIN, S_MAX, 1'b0, 1'b0);
    add_step(S_MAX, S_MAX, 1'b0, 1'b0);
    add_step(S_MAX, S_MAX, 1'b0, 1'b0);
    add_step(S_MIN, S_MIN, 1'b1, 1'b1);
    add_step(32'sd0, 32'sd0, 1'b0, 1'b0);
    add_step(-32'sd1, -32'sd1, 1'b0, 1'b0);
    add_step(-32'sd1, 32'sd0, 1'b1, 1'b0);
    add_step(32'sd0, -32'sd1, 1'b0, 1'b1);
    add_step(32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, 1'b1);
    add_step(32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, 1'b0);
    add_step(ONE * 10, ONE * 5, 1'b0, 1'b0);
    add_step(-ONE * 3, ONE, 1'b0, 1'b0);
    add_step(ONE, -ONE, 1'b1, 1'b0);
    add_step(S_MAX, 32'sd0, 1'b0, 1'b1);
    add_step(S_MAX, -ONE * 100, 1'b0, 1'b0);
    add_step(S_MIN, ONE * 100, 1'b0, 1'b0);
    add_step(S_MAX, S_MIN, 1'b1, 1'b0);
    add_step(S_MIN, S_MAX, 1'b0, 1'b1);
    wait_drained();
    queue_random_steps(80);
    wait_drained();

    // Zero gains, with the receiver holding off long enough to back up the input.
    set_gains('0, '0);
    queue_random_steps(60);
    hold_off_request = 1'b1;
    wait_drained();

    // Both gains at exactly one, run without any idling.
    set_gains(GAIN_ONE, GAIN_ONE);
    @(posedge clk);
    steady = 1'b1;
    queue_random_steps(90);
    wait_drained();
    @(posedge clk);
    steady = 1'b0;

    // Register values above one are used as one.
    set_gains(17'h1_FFFF, GAIN_ONE + 17'd1);
    queue_random_steps(60);
    wait_drained();

    set_gains(CFG_W'($urandom_range(65536)), CFG_W'($urandom_range(131071)));
    queue_random_steps(80);
    wait_drained();

    set_gains(17'd1, 17'd65535);
    queue_random_steps(80);
    wait_drained();
    repeat (20) @(negedge clk);

    if (expected_advantages.size() != 0) begin
      mismatch_count += expected_advantages.size();
      $display("%0d expected words never arrived", expected_advantages.size());
    end
    $display("Checked %0d advantage words under %0d gain settings, %0d of them saturated.",
             results_checked, gain_settings, saturated_results);
    $display("Failures: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS gae_advantage_recursion");
    end else begin
      $display("FAIL gae_advantage_recursion");
    end
    $finish;
  end

endmodule

### files.f
rtl/gaer_pkg.sv
rtl/gaer_front.sv
rtl/gaer_back.sv
rtl/gae_advantage_recursion.sv
tb/sv/gae_advantage_recursion_test.sv
